FILE: rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants of the command frame receiver
// Command codes, action encoding, payload geometry and the payload write
// request that travels between the frame parser and the payload store.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // ASCII command codes.
  localparam logic [7:0] CMD_START = 8'h73;  // 's'
  localparam logic [7:0] CMD_HALT  = 8'h68;  // 'h'
  localparam logic [7:0] CMD_GAINS = 8'h67;  // 'g'
  localparam logic [7:0] CMD_NONE  = 8'h6E;  // 'n'

  // Payload bytes sit at frame positions PAY_FIRST..PAY_LAST.
  localparam int unsigned NUM_WORDS = 6;
  localparam logic [8:0]  PAY_FIRST = 9'd2;
  localparam logic [8:0]  PAY_LAST  = 9'd25;

  typedef logic [31:0] word_t;
  typedef logic [8:0]  count_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_HALT  = 2'd2,
    ACT_GAINS = 2'd3
  } action_e;

  // Byte write into the payload store.
  typedef struct packed {
    logic       en;
    logic [2:0] word;
    logic [1:0] lane;
  } pay_wr_t;

endpackage

FILE: rtl/cfr_rx_if.sv
// ----------------------------------------------------------------------------
// cfr_rx_if: received byte channel
// Carries one serial data byte per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/cfr_res_if.sv
// ----------------------------------------------------------------------------
// cfr_res_if: frame result channel
// Carries the decoded action and the six raw gain words of a finished frame.
// ----------------------------------------------------------------------------
interface cfr_res_if;
  import cfr_pkg::*;

  logic    valid;
  logic    ready;
  action_e action;
  word_t   angle_kp;
  word_t   angle_ks;
  word_t   angle_kd;
  word_t   dist_kp;
  word_t   dist_ks;
  word_t   dist_kd;

  modport source (output valid, output action, output angle_kp, output angle_ks,
                  output angle_kd, output dist_kp, output dist_ks, output dist_kd,
                  input ready);
  modport sink   (input valid, input action, input angle_kp, input angle_ks,
                  input angle_kd, input dist_kp, input dist_ks, input dist_kd,
                  output ready);
endinterface

FILE: rtl/cfr_payload_store.sv
// ----------------------------------------------------------------------------
// cfr_payload_store: six little-endian payload words with byte writes
// Holds the gain words across frames and shows their value after this
// cycle's byte write, so a completing frame sees its own last byte.
// ----------------------------------------------------------------------------
module cfr_payload_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfr_pkg::pay_wr_t wr_i,
  input  logic [7:0]       data_i,
  output cfr_pkg::word_t   word_nxt_o [cfr_pkg::NUM_WORDS]
);
  import cfr_pkg::*;

  word_t words_q [NUM_WORDS];
  word_t words_d [NUM_WORDS];

  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      words_d[w] = words_q[w];
      if (wr_i.en && (wr_i.word == 3'(w))) begin
        for (int l = 0; l < 4; l++) begin
          if (wr_i.lane == 2'(l)) begin
            words_d[w][l*8 +: 8] = data_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        words_q[w] <= '0;
      end
    end else begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        words_q[w] <= words_d[w];
      end
    end
  end

  assign word_nxt_o = words_d;

endmodule

FILE: rtl/command_frame_receiver.sv
// ----------------------------------------------------------------------------
// command_frame_receiver: serial command frame parser
// Assembles received bytes into command frames and reports one action per
// completed frame.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries one received byte per item. A frame is a command byte, a
//   length byte L and L payload bytes. Payload bytes at frame positions 2 to
//   25 land in six 32-bit words, little-endian; later bytes are counted but
//   dropped. The words persist across frames.
//   res_o carries one item per completed frame: the action ('s' start,
//   'h' halt, 'g' set gains, anything else none) and the six words, which
//   read zero unless the action is set gains.
//   A byte accepted into the input register is parsed from there, and the
//   result it completes is registered in the output register and shown on res_o.
//   Throughput is one byte per cycle while res_o is not stalled, set by the single
//   parse stage between the input register and the result register.
//   Reset clears the byte counter, sets the command to 'n', the length to 0,
//   the payload words to zero and empties both pipeline registers.
//   When the receiver of res_o stalls, one result waits in the output
//   register; one more byte is held in the input register, and rx_i.ready
//   drops until the result is taken.
// ----------------------------------------------------------------------------
module command_frame_receiver (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfr_rx_if.sink    rx_i,
  cfr_res_if.source res_o
);
  import cfr_pkg::*;

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Frame state.
  count_t     count_q, count_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] len_q, len_d;

  // Output register.
  logic    out_valid_q, out_valid_d;
  action_e out_act_q;
  word_t   out_words_q [NUM_WORDS];

  logic       proc;
  logic       done;
  count_t     cnt_inc;
  logic [7:0] cmd_new;
  logic [7:0] len_new;
  logic [4:0] pay_off;
  action_e    act;
  pay_wr_t    pay_wr;
  word_t      word_nxt [NUM_WORDS];

  // The parse stage moves whenever the input register holds a byte and the output
  // register is free or drained in this cycle; the input register refills behind it.
  assign proc       = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || proc;

  always_comb begin
    cnt_inc = count_q + 9'd1;
    cmd_new = (cnt_inc == 9'd1) ? in_byte_q : cmd_q;
    len_new = (cnt_inc == 9'd2) ? in_byte_q : len_q;
    done    = (cnt_inc >= 9'd2) && ((cnt_inc - 9'd2) == {1'b0, len_new});

    // Position within the payload; only meaningful for positions 2 to 25.
    pay_off     = count_q[4:0] - 5'd2;
    pay_wr.en   = proc && (count_q >= PAY_FIRST) && (count_q <= PAY_LAST);
    pay_wr.word = pay_off[4:2];
    pay_wr.lane = pay_off[1:0];

    unique case (cmd_new)
      CMD_START: act = ACT_START;
      CMD_HALT:  act = ACT_HALT;
      CMD_GAINS: act = ACT_GAINS;
      default:   act = ACT_NONE;
    endcase

    count_d = count_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    if (proc) begin
      if (done) begin
        count_d = '0;
        cmd_d   = CMD_NONE;
        len_d   = '0;
      end else begin
        count_d = cnt_inc;
        cmd_d   = cmd_new;
        len_d   = len_new;
      end
    end

    out_valid_d = out_valid_q;
    if (proc && done) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  cfr_payload_store u_payload (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (pay_wr),
    .data_i     (in_byte_q),
    .word_nxt_o (word_nxt)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      count_q     <= '0;
      cmd_q       <= CMD_NONE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_i.ready) begin
        in_valid_q <= rx_i.valid;
      end
      count_q     <= count_d;
      cmd_q       <= cmd_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: the input byte and the result fields.
  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (proc && done) begin
      out_act_q <= act;
      for (int w = 0; w < NUM_WORDS; w++) begin
        out_words_q[w] <= (act == ACT_GAINS) ? word_nxt[w] : '0;
      end
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.action   = out_act_q;
  assign res_o.angle_kp = out_words_q[0];
  assign res_o.angle_ks = out_words_q[1];
  assign res_o.angle_kd = out_words_q[2];
  assign res_o.dist_kp  = out_words_q[3];
  assign res_o.dist_ks  = out_words_q[4];
  assign res_o.dist_kd  = out_words_q[5];

endmodule

FILE: rtl/cfr_checker.sv
// ----------------------------------------------------------------------------
// cfr_checker: port-level checks of the command frame receiver
// Watches both channels and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module cfr_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            rx_valid_i,
  input logic            rx_ready_i,
  input logic            res_valid_i,
  input logic            res_ready_i,
  input cfr_pkg::action_e res_action_i,
  input cfr_pkg::word_t  res_angle_kp_i,
  input cfr_pkg::word_t  res_dist_kd_i
);
  import cfr_pkg::*;

  // A stalled result stays offered with its action unchanged.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_action_i))
    else $error("result changed while stalled");

  // The byte side only stalls behind a waiting result.
  a_rx_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_i |-> res_valid_i)
    else $error("input stalled with empty output");

  // A new result always follows an accepted byte.
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(rx_valid_i && rx_ready_i, 2))
    else $error("result without a preceding byte");

  // The angle_kp and dist_kd gain words read zero unless the action is set gains.
  a_zero_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_action_i != ACT_GAINS) |->
      (res_angle_kp_i == '0) && (res_dist_kd_i == '0))
    else $error("nonzero words on a non-gains result");

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rx_valid_i     (rx_i.valid),
  .rx_ready_i     (rx_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .res_action_i   (res_o.action),
  .res_angle_kp_i (res_o.angle_kp),
  .res_dist_kd_i  (res_o.dist_kd)
);
